FILE: rtl/core/q24_8_fixed_point_alu_defines.svh
// Assertion macros used by the Q24.8 ALU back.
`ifndef Q24_8_FIXED_POINT_ALU_DEFINES_SVH
`define Q24_8_FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define Q24_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define Q24_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/q24alu_pkg.sv
// Types, mode codes and constants shared by the Q24.8 ALU modules.
`default_nettype none
package q24alu_pkg;

  localparam int DATA_W        = 32;
  localparam int MODE_W        = 4;
  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [MODE_W-1:0] MODE_ADD = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 4'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 4'd3;
  localparam logic [MODE_W-1:0] MODE_MIN = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MAX = 4'd5;
  localparam logic [MODE_W-1:0] MODE_INC = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DEC = 4'd7;
  localparam logic [MODE_W-1:0] MODE_INT = 4'd8;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     less;
    logic                     equal;
    logic                     greater;
    logic                     overflow;
    logic                     div_zero;
  } out_t;

  // A classified word: the input word plus its compare flags.
  typedef struct packed {
    in_t  item;
    logic less;
    logic equal;
    logic greater;
  } cls_t;

  localparam int CLS_W = $bits(cls_t);
  localparam int OUT_W = $bits(out_t);

endpackage
`default_nettype wire

FILE: rtl/core/q24alu_fifo.sv
// Small register queue used between the ALU front, back and result port.
`default_nettype none
module q24alu_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [0:DEPTH-1];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/q24alu_front.sv
// ALU front: takes input words and attaches the signed compare flags.
`default_nettype none
module q24alu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  q24alu_pkg::in_t     in_data,
  output logic                fr_valid,
  output q24alu_pkg::cls_t    fr_word,
  input  logic                fr_take
);
  import q24alu_pkg::*;

  logic valid_r, valid_nxt;
  cls_t word_r;
  logic accept;

  assign full      = valid_r && !fr_take;
  assign accept    = push && !full;
  assign valid_nxt = accept || (valid_r && !fr_take);
  assign fr_valid  = valid_r;
  assign fr_word   = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r.item    <= in_data;
      word_r.less    <= (in_data.operand_a <  in_data.operand_b);
      word_r.equal   <= (in_data.operand_a == in_data.operand_b);
      word_r.greater <= (in_data.operand_a >  in_data.operand_b);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/q24alu_back.sv
// ALU back: multiplier stage, result stage and a one-bit-per-stage divider.
`default_nettype none
`include "q24_8_fixed_point_alu_defines.svh"
module q24alu_back #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  q24alu_pkg::cls_t  in_word,
  output logic              in_take,
  input  logic              out_full,
  output logic              out_push,
  output q24alu_pkg::out_t  out_word
);
  import q24alu_pkg::*;

  localparam int DW = DATA_W + FRAC_BITS;
  localparam int NS = DW;

  logic adv;

  // Multiplier stage.
  logic                       s0_vld_r;
  cls_t                       s0_w_r;
  logic signed [2*DATA_W-1:0] s0_prod_r;

  // Result stage (index 0) followed by the divider stages.
  logic              vld_r [0:NS];
  logic              vld_nxt [0:NS];
  out_t              res_r [0:NS];
  out_t              res_nxt [0:NS];
  logic              isd_r [0:NS];
  logic              isd_nxt [0:NS];
  logic              neg_r [0:NS];
  logic              neg_nxt [0:NS];
  logic [DATA_W-1:0] rem_r [0:NS];
  logic [DATA_W-1:0] rem_nxt [0:NS];
  logic [DATA_W-1:0] dvs_r [0:NS];
  logic [DATA_W-1:0] dvs_nxt [0:NS];
  logic [DW-1:0]     dvd_r [0:NS];
  logic [DW-1:0]     dvd_nxt [0:NS];
  logic [DW-1:0]     q_r [0:NS];
  logic [DW-1:0]     q_nxt [0:NS];
  logic [DATA_W:0]   div_t [1:NS];
  logic              div_ge [1:NS];

  logic signed [DATA_W-1:0]   a_s, b_s, ai;
  logic [DATA_W:0]            s33;
  logic signed [2*DATA_W-1:0] mq;
  logic                       mrnd, arnd;
  logic [DATA_W-1:0]          ma, mb;
  logic [DW:0]                rr;

  assign adv     = !out_full;
  assign in_take = adv && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_w_r    <= in_word;
      s0_prod_r <= in_word.item.operand_a * in_word.item.operand_b;
    end
  end

  // Result stage: every mode but divide finishes here; divide is set up.
  // The divider stages follow in the same block, one quotient bit each.
  always_comb begin
    a_s  = s0_w_r.item.operand_a;
    b_s  = s0_w_r.item.operand_b;
    s33  = '0;
    mrnd = s0_prod_r[2*DATA_W-1] && (s0_prod_r[FRAC_BITS-1:0] != '0);
    mq   = (s0_prod_r >>> FRAC_BITS) + $signed({{(2*DATA_W-1){1'b0}}, mrnd});
    arnd = a_s[DATA_W-1] && (a_s[FRAC_BITS-1:0] != '0);
    ai   = (a_s >>> FRAC_BITS) + $signed({{(DATA_W-1){1'b0}}, arnd});
    ma   = a_s[DATA_W-1] ? (~a_s + DATA_W'(1)) : a_s;
    mb   = b_s[DATA_W-1] ? (~b_s + DATA_W'(1)) : b_s;

    res_nxt[0].value    = '0;
    res_nxt[0].less     = s0_w_r.less;
    res_nxt[0].equal    = s0_w_r.equal;
    res_nxt[0].greater  = s0_w_r.greater;
    res_nxt[0].overflow = 1'b0;
    res_nxt[0].div_zero = 1'b0;
    isd_nxt[0]          = 1'b0;

    case (s0_w_r.item.mode)
      MODE_ADD: begin
        s33 = {a_s[DATA_W-1], a_s} + {b_s[DATA_W-1], b_s};
        res_nxt[0].value    = s33[DATA_W-1:0];
        res_nxt[0].overflow = s33[DATA_W] ^ s33[DATA_W-1];
      end
      MODE_SUB: begin
        s33 = {a_s[DATA_W-1], a_s} - {b_s[DATA_W-1], b_s};
        res_nxt[0].value    = s33[DATA_W-1:0];
        res_nxt[0].overflow = s33[DATA_W] ^ s33[DATA_W-1];
      end
      MODE_MUL: begin
        res_nxt[0].value    = mq[DATA_W-1:0];
        res_nxt[0].overflow = (mq != {{DATA_W{mq[DATA_W-1]}}, mq[DATA_W-1:0]});
      end
      MODE_DIV: begin
        isd_nxt[0]          = 1'b1;
        res_nxt[0].div_zero = (b_s == '0);
      end
      MODE_MIN: begin
        res_nxt[0].value = s0_w_r.less ? a_s : b_s;
      end
      MODE_MAX: begin
        res_nxt[0].value = s0_w_r.greater ? a_s : b_s;
      end
      MODE_INC: begin
        s33 = {a_s[DATA_W-1], a_s} + (DATA_W+1)'(1);
        res_nxt[0].value    = s33[DATA_W-1:0];
        res_nxt[0].overflow = s33[DATA_W] ^ s33[DATA_W-1];
      end
      MODE_DEC: begin
        s33 = {a_s[DATA_W-1], a_s} - (DATA_W+1)'(1);
        res_nxt[0].value    = s33[DATA_W-1:0];
        res_nxt[0].overflow = s33[DATA_W] ^ s33[DATA_W-1];
      end
      MODE_INT: begin
        res_nxt[0].value = ai;
      end
      default: begin
        res_nxt[0].value = '0;
      end
    endcase

    vld_nxt[0] = s0_vld_r;
    neg_nxt[0] = a_s[DATA_W-1] ^ b_s[DATA_W-1];
    rem_nxt[0] = '0;
    dvs_nxt[0] = mb;
    dvd_nxt[0] = {ma, {FRAC_BITS{1'b0}}};
    q_nxt[0]   = '0;

    // Restoring divider: one quotient bit per stage, most significant first.
    for (int i = 1; i <= NS; i++) begin
      div_t[i]   = {rem_r[i-1], dvd_r[i-1][DW-1]};
      div_ge[i]  = (div_t[i] >= {1'b0, dvs_r[i-1]});
      rem_nxt[i] = div_ge[i] ? DATA_W'(div_t[i] - {1'b0, dvs_r[i-1]})
                             : div_t[i][DATA_W-1:0];
      dvd_nxt[i] = {dvd_r[i-1][DW-2:0], 1'b0};
      q_nxt[i]   = {q_r[i-1][DW-2:0], div_ge[i]};
      dvs_nxt[i] = dvs_r[i-1];
      vld_nxt[i] = vld_r[i-1];
      res_nxt[i] = res_r[i-1];
      isd_nxt[i] = isd_r[i-1];
      neg_nxt[i] = neg_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      for (int i = 0; i <= NS; i++) begin
        vld_r[i] <= vld_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= NS; i++) begin
        res_r[i] <= res_nxt[i];
        isd_r[i] <= isd_nxt[i];
        neg_r[i] <= neg_nxt[i];
        rem_r[i] <= rem_nxt[i];
        dvs_r[i] <= dvs_nxt[i];
        dvd_r[i] <= dvd_nxt[i];
        q_r[i]   <= q_nxt[i];
      end
    end
  end

  // Sign the quotient and check that it fits.
  always_comb begin
    rr       = neg_r[NS] ? (~{1'b0, q_r[NS]} + (DW+1)'(1)) : {1'b0, q_r[NS]};
    out_word = res_r[NS];
    if (isd_r[NS] && !res_r[NS].div_zero) begin
      out_word.value    = rr[DATA_W-1:0];
      out_word.overflow = (rr != {{(DW-DATA_W+1){rr[DATA_W-1]}}, rr[DATA_W-1:0]});
    end
  end

  assign out_push = adv && vld_r[NS];

  `Q24_ASSERT_IMP(a_dz_value, out_push && out_word.div_zero, (out_word.value == '0) && !out_word.overflow, "divide by zero word carries a value or overflow")
  `Q24_ASSERT_IMP(a_take_stall, in_take, !out_full, "word taken while the pipeline is stalled")
  `Q24_ASSERT_NXT(a_hold_stall, out_full, vld_r[NS] == $past(vld_r[NS]), "last stage moved while stalled")

endmodule
`default_nettype wire

FILE: rtl/core/q24_8_fixed_point_alu.sv
// Top level of the Q24.8 fixed-point ALU: front, queues and execution back.
// Path: an accepted word passes the front register, the middle queue, the multiplier stage,
// the result stage and every divider stage (one quotient bit per stage) for every mode.
// Throughput: one word per cycle while results are popped; the back stalls as a whole
// only when the two-entry result queue is full.
// Reset: synchronous, active low; clears valid bits and queue pointers, not the data.
`default_nettype none
module q24_8_fixed_point_alu #(
  parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  q24alu_pkg::in_t   in_data,
  output logic              empty,
  input  logic              pop,
  output q24alu_pkg::out_t  out_data
);
  import q24alu_pkg::*;

  // The front registers each incoming word and attaches the compare flags,
  // which every mode reports. It only stalls when the middle queue is full.
  logic fr_valid;
  cls_t fr_word;
  logic mid_full, mid_empty;
  logic [CLS_W-1:0] mid_rd;
  cls_t mid_word;

  // The back takes classified words from the middle queue, multiplies in its
  // first stage, finishes every non-divide mode in the second, and carries
  // those results alongside the divider pipeline so order is kept.
  logic bk_take, bk_push;
  out_t bk_word;
  logic res_full;
  logic [OUT_W-1:0] res_rd;

  q24alu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .fr_valid (fr_valid),
    .fr_word  (fr_word),
    .fr_take  (!mid_full)
  );

  // Middle queue: decouples the front from stalls in the back.
  q24alu_fifo #(
    .W     (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_valid && !mid_full),
    .wr_data (fr_word),
    .full    (mid_full),
    .rd_en   (bk_take),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  assign mid_word = cls_t'(mid_rd);

  q24alu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (!mid_empty),
    .in_word  (mid_word),
    .in_take  (bk_take),
    .out_full (res_full),
    .out_push (bk_push),
    .out_word (bk_word)
  );

  // Result queue: the oldest finished word sits on out_data while empty is low.
  q24alu_fifo #(
    .W     (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bk_push),
    .wr_data (bk_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign out_data = out_t'(res_rd);

endmodule
`default_nettype wire
